[hdl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, register indexes and the character classifier for the
// base64 decoder with position-keyed descrambling.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int BYTE_W   = 8;
	localparam int SEXTET_W = 6;
	localparam int GROUP_W  = 2;
	localparam int BUF_W    = 18;
	localparam int BURST    = 3;
	localparam int CNT_W    = 2;
	localparam int IDX_W    = 8;

	// Configuration register indexes.
	localparam logic [7:0] REG_KEY_OFFSET      = 8'd0;
	localparam logic [7:0] REG_SCRAMBLE_ENABLE = 8'd1;

	localparam logic [BYTE_W-1:0] KEY_OFFSET_RST = 8'd5;

	// Character constants.
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_PAD   = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_D0    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_D9    = 8'h39;
	localparam logic [BYTE_W-1:0] LOWER_BASE = 8'd26;
	localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd52;
	localparam logic [SEXTET_W-1:0] SX_PLUS  = 6'd62;
	localparam logic [SEXTET_W-1:0] SX_SLASH = 6'd63;

	typedef enum logic [1:0] {
		SYM_DATA,
		SYM_PAD,
		SYM_SKIP
	} sym_kind_t;

	typedef struct packed {
		sym_kind_t             kind;
		logic [SEXTET_W-1:0]   value;
	} sym_t;

	// A burst of decoded bytes produced by one character.
	typedef struct packed {
		logic [CNT_W-1:0]                 count;
		logic                             ended;
		logic [BURST-1:0][BYTE_W-1:0]     bytes;
	} burst_t;

	function automatic sym_t classify(input logic [BYTE_W-1:0] ch);
		sym_t        s;
		logic [7:0]  t;
		s.kind  = SYM_SKIP;
		s.value = '0;
		t       = '0;
		if (ch >= CH_UA && ch <= CH_UZ) begin
			t       = ch - CH_UA;
			s.kind  = SYM_DATA;
			s.value = t[SEXTET_W-1:0];
		end else if (ch >= CH_LA && ch <= CH_LZ) begin
			t       = ch - CH_LA + LOWER_BASE;
			s.kind  = SYM_DATA;
			s.value = t[SEXTET_W-1:0];
		end else if (ch >= CH_D0 && ch <= CH_D9) begin
			t       = ch - CH_D0 + DIGIT_BASE;
			s.kind  = SYM_DATA;
			s.value = t[SEXTET_W-1:0];
		end else if (ch == CH_PLUS) begin
			s.kind  = SYM_DATA;
			s.value = SX_PLUS;
		end else if (ch == CH_SLASH) begin
			s.kind  = SYM_DATA;
			s.value = SX_SLASH;
		end else if (ch == CH_PAD) begin
			s.kind  = SYM_PAD;
		end
		return s;
	endfunction

endpackage

[hdl/base64_decode_xor_descramble_top.sv]
// ----------------------------------------------------------------------------
// base64_decode_xor_descramble_top
// Base64 decoder that descrambles each output byte with a position key.
// ----------------------------------------------------------------------------
// Usage:
// One character enters per request on the s_axis channel (tdata = char_code,
// tuser = string_start). Each character is classified and decoded in one
// registered pass; a character that completes a group or a pad that closes
// one produces a burst of one to three bytes, otherwise nothing.
// Bytes leave on m_axis one per request: tdata = out_byte, tlast marks the
// last byte of the burst caused by one character, tuser = string_ended.
// The first byte of a burst passes the burst register, then the serializer
// slots, before it is valid on m_axis.
// Throughput: one character per cycle. The serializer drains one byte per
// cycle, so a three-byte burst is out before the next group completes; the
// burst register plus the serializer slots decouple the two sides.
// When the receiver stalls, the serializer holds its bytes, the burst
// register fills, and s_axis_tready drops until a burst moves on.
// Configuration writes (cfg_valid/cfg_ready, always ready) set key_offset
// (index 0) and scramble_enable (index 1); the user makes them only while
// idle; the block does not enforce it. Reset clears the decode state, the
// byte index and both queues, and loads key_offset = 5, scramble_enable = 1.
// ----------------------------------------------------------------------------
module base64_decode_xor_descramble_top import b64d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// input characters
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
	input  logic         s_axis_tuser,   // [0] string_start
	// decoded bytes
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata,   // [7:0] out_byte
	output logic         m_axis_tlast,   // run_last
	output logic         m_axis_tuser,   // [0] string_ended
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	logic [BYTE_W-1:0] key_offset_q;
	logic              scramble_enable_q;
	logic              in_take;
	logic              burst_valid;
	logic              burst_taken;
	burst_t            burst;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_offset_q      <= KEY_OFFSET_RST;
			scramble_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == REG_KEY_OFFSET) begin
				key_offset_q <= cfg_data;
			end else if (cfg_index == REG_SCRAMBLE_ENABLE) begin
				scramble_enable_q <= cfg_data[0];
			end
		end
	end

	// A new character is taken when the burst register is empty or its
	// burst moves into the serializer in this cycle.
	assign s_axis_tready = !burst_valid || burst_taken;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	b64d_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_take         (in_take),
		.char_code       (s_axis_tdata),
		.string_start    (s_axis_tuser),
		.key_offset      (key_offset_q),
		.scramble_enable (scramble_enable_q),
		.burst_taken     (burst_taken),
		.burst_valid     (burst_valid),
		.burst           (burst)
	);

	b64d_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.burst_valid   (burst_valid),
		.burst         (burst),
		.burst_taken   (burst_taken),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// A held burst always carries at least one byte.
	a_burst_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid |-> burst.count != '0)
		else $error("burst register holds an empty burst");

	// A byte that is not the last of its burst is followed by another.
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("burst ended without tlast");

	// After the last byte leaves with nothing queued, the output goes idle.
	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast && !burst_valid) |=> !m_axis_tvalid)
		else $error("output valid with no burst loaded");

endmodule

[hdl/b64d_core.sv]
// ----------------------------------------------------------------------------
// b64d_core
// Decode state and the single-pass decode of one character into a burst
// of up to three descrambled bytes, held in a burst register.
// ----------------------------------------------------------------------------
module b64d_core import b64d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_take,
	input  logic [BYTE_W-1:0]    char_code,
	input  logic                 string_start,
	input  logic [BYTE_W-1:0]    key_offset,
	input  logic                 scramble_enable,
	input  logic                 burst_taken,
	output logic                 burst_valid,
	output burst_t               burst
);

	logic [BUF_W-1:0]   buf_q;
	logic [GROUP_W-1:0] grp_q;
	logic [IDX_W-1:0]   idx_q;
	logic               ended_q;

	logic [BUF_W-1:0]   buf_e,   buf_n;
	logic [GROUP_W-1:0] grp_e,   grp_n;
	logic [IDX_W-1:0]   idx_e,   idx_n;
	logic               ended_e, ended_n;

	sym_t                          sym;
	logic [BUF_W+SEXTET_W-1:0]     full;
	logic [BURST-1:0][BYTE_W-1:0]  raw;
	logic [CNT_W-1:0]              cnt;
	logic                          pad_hit;
	logic [IDX_W-1:0]              key_base;
	burst_t                        res;

	logic   valid_s1;
	burst_t burst_s1;

	always_comb begin
		buf_e   = string_start ? '0 : buf_q;
		grp_e   = string_start ? '0 : grp_q;
		idx_e   = string_start ? '0 : idx_q;
		ended_e = string_start ? 1'b0 : ended_q;
		sym     = classify(char_code);
		full    = {buf_e, sym.value};
		buf_n   = buf_e;
		grp_n   = grp_e;
		ended_n = ended_e;
		raw     = '0;
		cnt     = '0;
		pad_hit = 1'b0;
		priority if (ended_e || sym.kind == SYM_SKIP) begin
			// nothing happens beyond the optional clear
		end else if (sym.kind == SYM_PAD) begin
			pad_hit = 1'b1;
			ended_n = 1'b1;
			buf_n   = '0;
			grp_n   = '0;
			if (grp_e == 2'd2) begin
				raw[0] = buf_e[11:4];
				cnt    = 2'd1;
			end else if (grp_e == 2'd3) begin
				raw[0] = buf_e[17:10];
				raw[1] = buf_e[9:2];
				cnt    = 2'd2;
			end
		end else if (grp_e == 2'd3) begin
			raw[0] = full[23:16];
			raw[1] = full[15:8];
			raw[2] = full[7:0];
			cnt    = 2'd3;
			buf_n  = '0;
			grp_n  = '0;
		end else begin
			buf_n = full[BUF_W-1:0];
			grp_n = grp_e + 2'd1;
		end

		key_base  = idx_e + key_offset;
		res.count = cnt;
		res.ended = pad_hit;
		for (int k = 0; k < BURST; k++) begin
			res.bytes[k] = raw[k] ^ ({BYTE_W{scramble_enable}} & (key_base + IDX_W'(k)));
		end
		idx_n = idx_e + IDX_W'(cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q    <= '0;
			grp_q    <= '0;
			idx_q    <= '0;
			ended_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_take) begin
				buf_q    <= buf_n;
				grp_q    <= grp_n;
				idx_q    <= idx_n;
				ended_q  <= ended_n;
				valid_s1 <= (cnt != '0);
			end else if (burst_taken) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			burst_s1 <= res;
		end
	end

	assign burst_valid = valid_s1;
	assign burst       = burst_s1;

endmodule

[hdl/b64d_ser.sv]
// ----------------------------------------------------------------------------
// b64d_ser
// Output serializer: loads a burst into three slots and shifts one byte
// per accepted output request.
// ----------------------------------------------------------------------------
module b64d_ser import b64d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 burst_valid,
	input  burst_t               burst,
	output logic                 burst_taken,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [BYTE_W-1:0]    m_axis_tdata,
	output logic                 m_axis_tlast,
	output logic                 m_axis_tuser
);

	logic [CNT_W-1:0]              cnt_q;
	logic                          ended_q;
	logic [BURST-1:0][BYTE_W-1:0]  slot_q;
	logic                          pop;

	assign pop         = m_axis_tvalid && m_axis_tready;
	assign burst_taken = burst_valid && (cnt_q == '0 || (cnt_q == 2'd1 && pop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (burst_taken) begin
			cnt_q <= burst.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (burst_taken) begin
			slot_q  <= burst.bytes;
			ended_q <= burst.ended;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = slot_q[0];
	assign m_axis_tlast  = (cnt_q == 2'd1);
	assign m_axis_tuser  = ended_q;

endmodule
